// File: design/bpc_pkg.sv
// Shared types, register indexes and reset constants for the button press classifier.
package bpc_pkg;

  localparam int unsigned TIME_WIDTH_DEF = 16;
  localparam int unsigned CFG_DATA_W     = 16;
  localparam int unsigned CFG_INDEX_W    = 3;
  localparam int unsigned DEB_W          = 8;
  localparam int unsigned CLICK_W        = 2;

  localparam logic [DEB_W-1:0]      DEBOUNCE_RST  = 8'd20;
  localparam logic [CFG_DATA_W-1:0] MIN_PRESS_RST = 16'd100;
  localparam logic [CFG_DATA_W-1:0] LONG_RST      = 16'd1500;
  localparam logic [CFG_DATA_W-1:0] WINDOW_RST    = 16'd1500;
  localparam logic [CLICK_W-1:0]    CLICKS_TRIPLE = 2'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE  = 3'd0,
    REG_MIN_PRESS = 3'd1,
    REG_LONG      = 3'd2,
    REG_WINDOW    = 3'd3,
    REG_TRIPLE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [DEB_W-1:0]      debounce_ticks;
    logic [CFG_DATA_W-1:0] min_press_ticks;
    logic [CFG_DATA_W-1:0] long_press_ticks;
    logic [CFG_DATA_W-1:0] click_window_ticks;
    logic                  allow_triple;
  } cfg_t;

  typedef struct packed {
    logic               long_pulse;
    logic               short_pulse;
    logic               triple_pulse;
    logic               window_active;
    logic [CLICK_W-1:0] clicks_pending;
  } result_t;

endpackage

// File: design/button_press_classifier.sv
// Top level of the button press classifier: input register, tick logic, result register.
// A held input word enters the result register when the output is empty or read.
// One word per clock while out_ready keeps up; the single tick stage updates all state.
// While a finished word waits for out_ready the input register holds one more word.
// Reset (rst_n low, synchronous) returns to idle with all counters cleared and
// configuration registers at their default values.
module button_press_classifier #(
  parameter int unsigned TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_key_level,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_long_pulse,
  output logic                              out_short_pulse,
  output logic                              out_triple_pulse,
  output logic                              out_window_active,
  output logic [bpc_pkg::CLICK_W-1:0]       out_clicks_pending,
  input  logic                              cfg_wr_en,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::result_t res;
  bpc_pkg::result_t res_r;
  logic             in_vld_r;
  logic             key_r;
  logic             out_vld_r;
  logic             advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_q     (cfg)
  );

  bpc_tick #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (advance),
    .key     (key_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      key_r <= in_key_level;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_long_pulse     = res_r.long_pulse;
  assign out_short_pulse    = res_r.short_pulse;
  assign out_triple_pulse   = res_r.triple_pulse;
  assign out_window_active  = res_r.window_active;
  assign out_clicks_pending = res_r.clicks_pending;

endmodule

// File: design/bpc_cfg.sv
// Configuration register bank of the button press classifier.
module bpc_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bpc_pkg::cfg_t                      cfg_q
);

  bpc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks     <= bpc_pkg::DEBOUNCE_RST;
      cfg_r.min_press_ticks    <= bpc_pkg::MIN_PRESS_RST;
      cfg_r.long_press_ticks   <= bpc_pkg::LONG_RST;
      cfg_r.click_window_ticks <= bpc_pkg::WINDOW_RST;
      cfg_r.allow_triple       <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpc_pkg::REG_DEBOUNCE:  cfg_r.debounce_ticks     <= cfg_wdata[bpc_pkg::DEB_W-1:0];
        bpc_pkg::REG_MIN_PRESS: cfg_r.min_press_ticks    <= cfg_wdata;
        bpc_pkg::REG_LONG:      cfg_r.long_press_ticks   <= cfg_wdata;
        bpc_pkg::REG_WINDOW:    cfg_r.click_window_ticks <= cfg_wdata;
        bpc_pkg::REG_TRIPLE:    cfg_r.allow_triple       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_q = cfg_r;

endmodule

// File: design/bpc_tick.sv
// Per-tick classifier state and its next-state logic.
module bpc_tick #(
  parameter int unsigned TIME_WIDTH = bpc_pkg::TIME_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick_en,
  input  logic               key,
  input  bpc_pkg::cfg_t      cfg,
  output bpc_pkg::result_t   res
);

  localparam int unsigned CW = (TIME_WIDTH > bpc_pkg::CFG_DATA_W) ? TIME_WIDTH
                                                                   : bpc_pkg::CFG_DATA_W;
  localparam logic [TIME_WIDTH-1:0]       TIME_MAX = {TIME_WIDTH{1'b1}};
  localparam logic [bpc_pkg::DEB_W-1:0]   DEB_MAX  = {bpc_pkg::DEB_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_WAIT_REL = 2'd3
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [bpc_pkg::DEB_W-1:0]      deb_cnt_r, deb_cnt_nxt, deb_inc;
  logic [TIME_WIDTH-1:0]          held_r, held_nxt, held_inc;
  logic [TIME_WIDTH-1:0]          since_r, since_nxt, since_adv;
  logic [bpc_pkg::CLICK_W-1:0]    clicks_r, clicks_nxt, clicks_win;
  logic                           active;
  logic                           lp, sp, tp;
  logic [CW-1:0]                  window_ext, long_ext, min_ext;

  assign window_ext = CW'(cfg.click_window_ticks);
  assign long_ext   = CW'(cfg.long_press_ticks);
  assign min_ext    = CW'(cfg.min_press_ticks);

  always_comb begin
    since_adv = since_r;
    if (clicks_r != '0 && since_r != TIME_MAX) begin
      since_adv = since_r + 1'b1;
    end
    deb_inc  = (deb_cnt_r != DEB_MAX) ? deb_cnt_r + 1'b1 : deb_cnt_r;
    held_inc = (held_r != TIME_MAX) ? held_r + 1'b1 : held_r;

    active     = 1'b0;
    clicks_win = clicks_r;
    since_nxt  = since_adv;
    if (cfg.allow_triple && clicks_r != '0) begin
      active = 1'b1;
      if (CW'(since_adv) > window_ext) begin
        clicks_win = '0;
        since_nxt  = '0;
        active     = 1'b0;
      end
    end else if (!cfg.allow_triple) begin
      clicks_win = '0;
      since_nxt  = '0;
    end
    clicks_nxt = clicks_win;

    lp          = 1'b0;
    sp          = 1'b0;
    tp          = 1'b0;
    phase_nxt   = phase_r;
    deb_cnt_nxt = deb_cnt_r;
    held_nxt    = held_r;

    case (phase_r)
      PH_IDLE: begin
        if (key) begin
          deb_cnt_nxt = '0;
          if (cfg.debounce_ticks == '0) begin
            phase_nxt = PH_PRESSED;
            held_nxt  = '0;
          end else begin
            phase_nxt = PH_DEBOUNCE;
          end
        end
      end
      PH_DEBOUNCE: begin
        deb_cnt_nxt = deb_inc;
        if (deb_inc >= cfg.debounce_ticks) begin
          if (key) begin
            phase_nxt = PH_PRESSED;
            held_nxt  = '0;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_PRESSED: begin
        if (key) begin
          held_nxt = held_inc;
          if (CW'(held_inc) >= long_ext) begin
            lp        = 1'b1;
            phase_nxt = PH_WAIT_REL;
          end
        end else begin
          phase_nxt = PH_IDLE;
          if (CW'(held_r) > min_ext && CW'(held_r) < long_ext) begin
            if (cfg.allow_triple) begin
              if (clicks_win == '0 || CW'(since_nxt) > window_ext) begin
                clicks_nxt = 2'd1;
              end else begin
                clicks_nxt = clicks_win + 1'b1;
              end
              since_nxt = '0;
              if (clicks_nxt >= bpc_pkg::CLICKS_TRIPLE) begin
                tp         = 1'b1;
                clicks_nxt = '0;
                active     = 1'b0;
              end
            end else begin
              sp = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!key) begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase

    res.long_pulse     = lp;
    res.short_pulse    = sp;
    res.triple_pulse   = tp;
    res.window_active  = active;
    res.clicks_pending = clicks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      deb_cnt_r <= '0;
      held_r    <= '0;
      since_r   <= '0;
      clicks_r  <= '0;
    end else if (tick_en) begin
      phase_r   <= phase_nxt;
      deb_cnt_r <= deb_cnt_nxt;
      held_r    <= held_nxt;
      since_r   <= since_nxt;
      clicks_r  <= clicks_nxt;
    end
  end

endmodule

// File: bench/button_press_classifier_test.sv
// Self-checking testbench for the button press classifier: random key ticks, predicted results.
module button_press_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TW          = bpc_pkg::TIME_WIDTH_DEF;
  localparam int IDX_W       = bpc_pkg::CFG_INDEX_W;
  localparam int DATA_W      = bpc_pkg::CFG_DATA_W;
  localparam int PRESS_CAP   = 40;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 100000;

  typedef enum logic [1:0] {
    KEY_IDLE,
    KEY_DEBOUNCE,
    KEY_HELD,
    KEY_WAIT_RELEASE
  } key_phase_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_key_level = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_long_pulse;
  logic                            out_short_pulse;
  logic                            out_triple_pulse;
  logic                            out_window_active;
  logic [bpc_pkg::CLICK_W-1:0]     out_clicks_pending;
  logic                            cfg_wr_en = 1'b0;
  logic [IDX_W-1:0]                cfg_index = '0;
  logic [DATA_W-1:0]               cfg_wdata = '0;

  logic               key_levels_q[$];
  bpc_pkg::result_t   predicted_q[$];
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 mismatches = 0;
  int                 cycle = 0;

  bpc_pkg::cfg_t      cfg_shadow = '{bpc_pkg::DEBOUNCE_RST, bpc_pkg::MIN_PRESS_RST,
                                     bpc_pkg::LONG_RST, bpc_pkg::WINDOW_RST, 1'b0};
  key_phase_t         key_state = KEY_IDLE;
  logic [bpc_pkg::DEB_W-1:0]   debounce_cnt = '0;
  logic [TW-1:0]               held_ticks = '0;
  logic [TW-1:0]               since_click = '0;
  logic [bpc_pkg::CLICK_W-1:0] click_cnt = '0;

  button_press_classifier DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_key_level       (in_key_level),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_long_pulse     (out_long_pulse),
    .out_short_pulse    (out_short_pulse),
    .out_triple_pulse   (out_triple_pulse),
    .out_window_active  (out_window_active),
    .out_clicks_pending (out_clicks_pending),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic bpc_pkg::result_t classify_tick(input logic key);
    bpc_pkg::result_t r;
    r = '0;
    if (click_cnt != 0 && since_click != '1) since_click++;
    if (cfg_shadow.allow_triple && click_cnt != 0) begin
      r.window_active = 1'b1;
      if (since_click > cfg_shadow.click_window_ticks) begin
        click_cnt = '0;
        since_click = '0;
        r.window_active = 1'b0;
      end
    end else if (!cfg_shadow.allow_triple) begin
      click_cnt = '0;
      since_click = '0;
    end
    case (key_state)
      KEY_IDLE: begin
        if (key) begin
          debounce_cnt = '0;
          if (cfg_shadow.debounce_ticks == 0) begin
            key_state = KEY_HELD;
            held_ticks = '0;
          end else begin
            key_state = KEY_DEBOUNCE;
          end
        end
      end
      KEY_DEBOUNCE: begin
        if (debounce_cnt != '1) debounce_cnt++;
        if (debounce_cnt >= cfg_shadow.debounce_ticks) begin
          if (key) begin
            key_state = KEY_HELD;
            held_ticks = '0;
          end else begin
            key_state = KEY_IDLE;
          end
        end
      end
      KEY_HELD: begin
        if (key) begin
          if (held_ticks != '1) held_ticks++;
          if (held_ticks >= cfg_shadow.long_press_ticks) begin
            r.long_pulse = 1'b1;
            key_state = KEY_WAIT_RELEASE;
          end
        end else begin
          key_state = KEY_IDLE;
          if (held_ticks > cfg_shadow.min_press_ticks &&
              held_ticks < cfg_shadow.long_press_ticks) begin
            if (cfg_shadow.allow_triple) begin
              if (click_cnt == 0 || since_click > cfg_shadow.click_window_ticks) begin
                click_cnt = 2'd1;
              end else begin
                click_cnt++;
              end
              since_click = '0;
              if (click_cnt >= bpc_pkg::CLICKS_TRIPLE) begin
                r.triple_pulse = 1'b1;
                click_cnt = '0;
                r.window_active = 1'b0;
              end
            end else begin
              r.short_pulse = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!key) key_state = KEY_IDLE;
      end
    endcase
    r.clicks_pending = click_cnt;
    return r;
  endfunction

  function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] data);
    case (idx)
      bpc_pkg::REG_DEBOUNCE:  cfg_shadow.debounce_ticks = data[bpc_pkg::DEB_W-1:0];
      bpc_pkg::REG_MIN_PRESS: cfg_shadow.min_press_ticks = data;
      bpc_pkg::REG_LONG:      cfg_shadow.long_press_ticks = data;
      bpc_pkg::REG_WINDOW:    cfg_shadow.click_window_ticks = data;
      bpc_pkg::REG_TRIPLE:    cfg_shadow.allow_triple = data[0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_q.push_back(classify_tick(in_key_level));
      if (!in_valid || in_ready) begin
        if (key_levels_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_key_level <= key_levels_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bpc_pkg::result_t got;
    bpc_pkg::result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_long_pulse, out_short_pulse, out_triple_pulse, out_window_active,
               out_clicks_pending};
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %b", got));
        end else begin
          want = predicted_q.pop_front();
          if (got.long_pulse !== want.long_pulse)
            report_mismatch($sformatf("long_pulse %b, want %b", got.long_pulse,
                                      want.long_pulse));
          if (got.short_pulse !== want.short_pulse)
            report_mismatch($sformatf("short_pulse %b, want %b", got.short_pulse,
                                      want.short_pulse));
          if (got.triple_pulse !== want.triple_pulse)
            report_mismatch($sformatf("triple_pulse %b, want %b", got.triple_pulse,
                                      want.triple_pulse));
          if (got.window_active !== want.window_active)
            report_mismatch($sformatf("window_active %b, want %b", got.window_active,
                                      want.window_active));
          if (got.clicks_pending !== want.clicks_pending)
            report_mismatch($sformatf("clicks_pending %0d, want %0d", got.clicks_pending,
                                      want.clicks_pending));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (key_levels_q.size() != 0 || in_valid || predicted_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config(input logic [DATA_W-1:0] deb, mn, lng, win, triple);
    logic [DATA_W-1:0] words [5];
    logic [IDX_W-1:0]  spare;
    words = '{deb, mn, lng, win, triple};
    spare = IDX_W'(bpc_pkg::REG_TRIPLE + 1 + $urandom_range(2));
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= IDX_W'(i);
      cfg_wdata <= words[i];
      apply_reg(IDX_W'(i), words[i]);
    end
    @(posedge clk);
    cfg_index <= spare;
    cfg_wdata <= DATA_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_pattern(input logic [31:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) key_levels_q.push_back(pat[i]);
  endtask

  task automatic fill_presses(input int n);
    int  deb;
    int  t_min;
    int  t_long;
    int  t_win;
    int  target;
    bit  bounce;
    deb    = cfg_shadow.debounce_ticks;
    t_min  = (cfg_shadow.min_press_ticks > PRESS_CAP) ? PRESS_CAP
                                                      : cfg_shadow.min_press_ticks;
    t_long = (cfg_shadow.long_press_ticks > PRESS_CAP + 1) ? PRESS_CAP + 1
                                                           : cfg_shadow.long_press_ticks;
    t_win  = (cfg_shadow.click_window_ticks > PRESS_CAP) ? PRESS_CAP
                                                         : cfg_shadow.click_window_ticks;
    while (key_levels_q.size() < n) begin
      if ($urandom_range(9) < 2) begin
        repeat ($urandom_range(8, 1)) key_levels_q.push_back(1'($urandom));
      end else begin
        case ($urandom_range(3))
          0: target = (t_min + 2 <= t_long) ? $urandom_range(t_long - 1, t_min + 1)
                                            : $urandom_range(PRESS_CAP);
          1: target = $urandom_range(t_min);
          2: target = $urandom_range(t_long + 2, t_long);
          default: target = $urandom_range(t_long + 2);
        endcase
        bounce = ($urandom_range(2) == 0);
        key_levels_q.push_back(1'b1);
        for (int i = 1; i < deb; i++) key_levels_q.push_back(bounce ? 1'($urandom) : 1'b1);
        if (deb != 0 && $urandom_range(7) == 0) begin
          key_levels_q.push_back(1'b0);
        end else begin
          if (deb != 0) key_levels_q.push_back(1'b1);
          repeat (target) key_levels_q.push_back(1'b1);
          key_levels_q.push_back(1'b0);
        end
        repeat ($urandom_range(t_win + 3)) key_levels_q.push_back(1'b0);
      end
    end
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] deb, mn, lng, win, triple,
                           input int n);
    drain();
    load_config(deb, mn, lng, win, triple);
    fill_presses(n);
  endtask

  task automatic random_phase(input int n);
    run_phase({8'($urandom), 8'($urandom_range(4))}, 16'($urandom_range(4)),
              16'($urandom_range(12, 1)), 16'($urandom_range(40, 5)),
              {15'($urandom), 1'($urandom)}, n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 9;
    recv_stall_pct = 51;
    // Zero debounce with a one-tick long press, then a release with nothing held.
    drain();
    load_config(16'd0, 16'd0, 16'd1, 16'd0, 16'd0);
    push_pattern(32'b11010, 5);
    // A bounce dropped at the resample tick, a triple, then a click left to expire.
    drain();
    load_config(16'd1, 16'd0, 16'd3, 16'd5, 16'd1);
    push_pattern(32'b10_1110_1110_1110_1110_000000, 24);
    repeat (3) random_phase(110);
    run_phase(16'hA5FF, 16'd0, 16'd1, 16'd0, 16'hFFFE, 200);

    send_idle_pct  = 51;
    recv_stall_pct = 9;
    repeat (2) random_phase(110);
    run_phase(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 60);
    run_phase(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 100);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (2) random_phase(110);
    run_phase(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd1, 60);
    run_phase(16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 60);
    drain();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/bpc_pkg.sv
design/bpc_cfg.sv
design/bpc_tick.sv
design/button_press_classifier.sv
bench/button_press_classifier_test.sv
